@@ rtl/hpt_pkg.sv @@
// hpt_pkg: types and constants shared by the header parameter tokenizer
// holds transaction structs, parse phase and controller enums, kind codes
// no dependencies
package hpt_pkg;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       has_byte;
        logic       last;
    } hpt_in_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic [2:0] kind;
        logic       space_lost;
        logic       run_last;
    } hpt_out_t;

    localparam logic [2:0] K_NAME  = 3'd0;
    localparam logic [2:0] K_VALUE = 3'd1;
    localparam logic [2:0] K_PEND  = 3'd2;
    localparam logic [2:0] K_OK    = 3'd3;
    localparam logic [2:0] K_ERR   = 3'd4;

    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_EQ     = 8'h3D;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;

    typedef enum logic [2:0] {
        PH_START,
        PH_BARE,
        PH_NAME,
        PH_AFTER_EQ,
        PH_VALUE,
        PH_QUOTED,
        PH_ESCAPE,
        PH_AFTER_QUOTE
    } hpt_phase_t;

    typedef enum logic [1:0] {
        SEL_FLUSH,
        SEL_BYTE,
        SEL_PEND,
        SEL_END
    } hpt_sel_t;

    typedef enum logic [1:0] {
        C_IDLE,
        C_RUN,
        C_FLUSH
    } hpt_ctl_state_t;

    typedef struct packed {
        logic     load;
        logic     emit;
        hpt_sel_t sel;
    } hpt_cmd_t;

    typedef struct packed {
        logic flush_left;
        logic byte_left;
        logic pend_left;
        logic end_left;
        logic out_free;
    } hpt_stat_t;

    function automatic logic is_ws(input logic [7:0] b);
        return (b == 8'h20) || (b == 8'h09) || (b == 8'h0A) ||
               (b == 8'h0B) || (b == 8'h0C) || (b == 8'h0D);
    endfunction

endpackage

@@ rtl/hpt_ram.sv @@
// hpt_ram: generic single write port ram with registered read
// no dependencies
module hpt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                   aclk,
    input  logic                                   we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/hpt_ctrl.sv @@
// hpt_ctrl: sequencing state machine of the tokenizer
// steps through held whitespace, item byte, parameter end and header end
// depends on hpt_pkg
module hpt_ctrl import hpt_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  hpt_stat_t stat,
    output hpt_cmd_t  cmd
);

    hpt_ctl_state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= C_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        s_ready    = 1'b0;
        cmd.load   = 1'b0;
        cmd.emit   = 1'b0;
        cmd.sel    = SEL_BYTE;
        unique case (state_reg)
            C_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = C_RUN;
                end
            end
            C_RUN: begin
                priority if (stat.flush_left) begin
                    state_next = C_FLUSH;
                end else if (stat.byte_left) begin
                    cmd.sel  = SEL_BYTE;
                    cmd.emit = stat.out_free;
                end else if (stat.pend_left) begin
                    cmd.sel  = SEL_PEND;
                    cmd.emit = stat.out_free;
                end else if (stat.end_left) begin
                    cmd.sel  = SEL_END;
                    cmd.emit = stat.out_free;
                end else begin
                    state_next = C_IDLE;
                end
            end
            C_FLUSH: begin
                cmd.sel = SEL_FLUSH;
                if (stat.out_free) begin
                    cmd.emit   = 1'b1;
                    state_next = C_RUN;
                end
            end
            default: begin
                state_next = C_IDLE;
            end
        endcase
    end

endmodule

@@ rtl/hpt_datapath.sv @@
// hpt_datapath: parse state, emission plan, held whitespace and output register
// depends on hpt_pkg and hpt_ram
module hpt_datapath import hpt_pkg::*; #(
    parameter int HELD_SPACE_DEPTH = 16
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      cfg_we,
    input  logic      cfg_wdata,
    input  hpt_in_t   s_data,
    input  hpt_cmd_t  cmd,
    output hpt_stat_t stat,
    output logic      m_valid,
    input  logic      m_ready,
    output hpt_out_t  m_data
);

    localparam int AW = (HELD_SPACE_DEPTH > 1) ? $clog2(HELD_SPACE_DEPTH) : 1;
    localparam int CW = $clog2(HELD_SPACE_DEPTH + 1);
    localparam logic [CW-1:0] DEPTH_C = CW'(HELD_SPACE_DEPTH);

    hpt_phase_t    phase_reg, phase_next;
    logic          cs_reg, cs_next;
    logic [CW-1:0] hc_reg, hc_next;
    logic          po_reg, po_next;
    logic          flag_reg, flag_next;
    logic          bare_reg;

    logic [CW-1:0] fcnt_reg, fcnt_next;
    logic [CW-1:0] fidx_reg, fidx_next;
    logic          byte_reg, byte_next;
    logic [7:0]    bval_reg, bval_next;
    logic [2:0]    bkind_reg, bkind_next;
    logic          pend_reg, pend_next;
    logic          end_reg, end_next;
    logic          err_reg, err_next;

    logic          mv_reg, mv_next;
    hpt_out_t      mdata_reg, mdata_next;

    hpt_phase_t    ph_w;
    logic          cs_w, po_w, fl_w, do_text, pend_w, byte_w, end_w, err_w, ram_we;
    logic [CW-1:0] hc_w, flush_w;
    logic [2:0]    kind_w;
    logic [AW-1:0] waddr_w;
    logic [7:0]    b;
    logic [7:0]    ram_rdata;

    assign b = s_data.data_byte;

    hpt_ram #(
        .WIDTH(8),
        .DEPTH(HELD_SPACE_DEPTH)
    ) u_held (
        .aclk  (aclk),
        .we    (cmd.load && ram_we),
        .waddr (waddr_w),
        .wdata (b),
        .raddr (fidx_reg[AW-1:0]),
        .rdata (ram_rdata)
    );

    // transaction decode against current parse state
    always_comb begin
        ph_w    = phase_reg;
        cs_w    = cs_reg;
        hc_w    = hc_reg;
        po_w    = po_reg;
        fl_w    = flag_reg;
        do_text = 1'b0;
        kind_w  = K_NAME;
        pend_w  = 1'b0;
        byte_w  = 1'b0;
        end_w   = 1'b0;
        err_w   = 1'b0;
        ram_we  = 1'b0;
        flush_w = '0;
        waddr_w = '0;
        if (s_data.has_byte || s_data.last) begin
            if (phase_reg == PH_START) begin
                cs_w = 1'b0;
                hc_w = '0;
                po_w = 1'b0;
                fl_w = 1'b0;
                ph_w = bare_reg ? PH_BARE : PH_NAME;
            end
            if (s_data.has_byte) begin
                unique case (ph_w)
                    PH_BARE: begin
                        if (b == CH_SEMI) begin
                            pend_w = 1'b1;
                        end else begin
                            do_text = 1'b1;
                        end
                    end
                    PH_NAME: begin
                        po_w = 1'b1;
                        if (b == CH_SEMI) begin
                            pend_w = 1'b1;
                        end else if (b == CH_EQ) begin
                            cs_w = 1'b0;
                            hc_w = '0;
                            ph_w = PH_AFTER_EQ;
                        end else begin
                            do_text = 1'b1;
                        end
                    end
                    PH_AFTER_EQ: begin
                        if (b == CH_QUOTE) begin
                            ph_w = PH_QUOTED;
                        end else begin
                            cs_w = 1'b0;
                            hc_w = '0;
                            ph_w = PH_VALUE;
                            if (b == CH_SEMI) begin
                                pend_w = 1'b1;
                            end else begin
                                do_text = 1'b1;
                                kind_w  = K_VALUE;
                            end
                        end
                    end
                    PH_VALUE: begin
                        if (b == CH_SEMI) begin
                            pend_w = 1'b1;
                        end else begin
                            do_text = 1'b1;
                            kind_w  = K_VALUE;
                        end
                    end
                    PH_QUOTED: begin
                        if (b == CH_BSLASH) begin
                            ph_w = PH_ESCAPE;
                        end else if (b == CH_QUOTE) begin
                            ph_w = PH_AFTER_QUOTE;
                        end else begin
                            byte_w = 1'b1;
                            kind_w = K_VALUE;
                        end
                    end
                    PH_ESCAPE: begin
                        ph_w   = PH_QUOTED;
                        byte_w = 1'b1;
                        kind_w = K_VALUE;
                    end
                    PH_AFTER_QUOTE: begin
                        if (b == CH_SEMI) begin
                            pend_w = 1'b1;
                        end
                    end
                    PH_START: begin
                        ph_w = PH_NAME;
                    end
                endcase
                if (do_text) begin
                    if (is_ws(b)) begin
                        if (cs_w) begin
                            if (hc_w < DEPTH_C) begin
                                ram_we  = 1'b1;
                                waddr_w = hc_w[AW-1:0];
                                hc_w    = hc_w + CW'(1);
                            end else begin
                                fl_w = 1'b1;
                            end
                        end
                    end else begin
                        flush_w = hc_w;
                        hc_w    = '0;
                        cs_w    = 1'b1;
                        byte_w  = 1'b1;
                    end
                end
                if (pend_w) begin
                    cs_w = 1'b0;
                    hc_w = '0;
                    po_w = 1'b0;
                    ph_w = PH_NAME;
                end
            end
            if (s_data.last) begin
                if (ph_w == PH_QUOTED || ph_w == PH_ESCAPE) begin
                    err_w = 1'b1;
                end else if (ph_w != PH_NAME || po_w) begin
                    pend_w = 1'b1;
                end
                end_w = 1'b1;
                cs_w  = 1'b0;
                hc_w  = '0;
                po_w  = 1'b0;
                ph_w  = PH_START;
            end
        end
    end

    // state, plan and output register updates
    always_comb begin
        phase_next = phase_reg;
        cs_next    = cs_reg;
        hc_next    = hc_reg;
        po_next    = po_reg;
        flag_next  = flag_reg;
        fcnt_next  = fcnt_reg;
        fidx_next  = fidx_reg;
        byte_next  = byte_reg;
        bval_next  = bval_reg;
        bkind_next = bkind_reg;
        pend_next  = pend_reg;
        end_next   = end_reg;
        err_next   = err_reg;
        mv_next    = mv_reg && !m_ready;
        mdata_next = mdata_reg;
        if (cmd.load) begin
            phase_next = ph_w;
            cs_next    = cs_w;
            hc_next    = hc_w;
            po_next    = po_w;
            flag_next  = fl_w;
            fcnt_next  = flush_w;
            fidx_next  = '0;
            byte_next  = byte_w;
            bval_next  = b;
            bkind_next = kind_w;
            pend_next  = pend_w;
            end_next   = end_w;
            err_next   = err_w;
        end
        if (cmd.emit) begin
            mv_next               = 1'b1;
            mdata_next.space_lost = flag_reg;
            unique case (cmd.sel)
                SEL_FLUSH: begin
                    mdata_next.out_byte = ram_rdata;
                    mdata_next.kind     = bkind_reg;
                    mdata_next.run_last = 1'b0;
                    fidx_next           = fidx_reg + CW'(1);
                end
                SEL_BYTE: begin
                    mdata_next.out_byte = bval_reg;
                    mdata_next.kind     = bkind_reg;
                    mdata_next.run_last = !pend_reg && !end_reg;
                    byte_next           = 1'b0;
                end
                SEL_PEND: begin
                    mdata_next.out_byte = 8'h00;
                    mdata_next.kind     = K_PEND;
                    mdata_next.run_last = !end_reg;
                    pend_next           = 1'b0;
                end
                SEL_END: begin
                    mdata_next.out_byte = 8'h00;
                    mdata_next.kind     = err_reg ? K_ERR : K_OK;
                    mdata_next.run_last = 1'b1;
                    end_next            = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_START;
            cs_reg    <= 1'b0;
            hc_reg    <= '0;
            po_reg    <= 1'b0;
            flag_reg  <= 1'b0;
            bare_reg  <= 1'b0;
            fcnt_reg  <= '0;
            fidx_reg  <= '0;
            byte_reg  <= 1'b0;
            pend_reg  <= 1'b0;
            end_reg   <= 1'b0;
            mv_reg    <= 1'b0;
        end else begin
            phase_reg <= phase_next;
            cs_reg    <= cs_next;
            hc_reg    <= hc_next;
            po_reg    <= po_next;
            flag_reg  <= flag_next;
            if (cfg_we) begin
                bare_reg <= cfg_wdata;
            end
            fcnt_reg  <= fcnt_next;
            fidx_reg  <= fidx_next;
            byte_reg  <= byte_next;
            pend_reg  <= pend_next;
            end_reg   <= end_next;
            mv_reg    <= mv_next;
        end
    end

    always_ff @(posedge aclk) begin
        bval_reg  <= bval_next;
        bkind_reg <= bkind_next;
        err_reg   <= err_next;
        mdata_reg <= mdata_next;
    end

    assign stat.flush_left = (fidx_reg != fcnt_reg);
    assign stat.byte_left  = byte_reg;
    assign stat.pend_left  = pend_reg;
    assign stat.end_left   = end_reg;
    assign stat.out_free   = !mv_reg || m_ready;

    assign m_valid = mv_reg;
    assign m_data  = mdata_reg;

endmodule

@@ rtl/header_parameter_tokenizer_core.sv @@
// sequence: an accepted transaction loads the plan registers, then each result is emitted
// into the output register behind m_valid, held back while that register is not free;
// a new transaction is accepted only in idle, after all R results and F flushed held
// whitespace bytes are out; each flushed byte waits on the registered ram read
// reset: synchronous active-low aresetn returns to start of header with empty buffer
// depends on hpt_pkg, hpt_ctrl, hpt_datapath, hpt_ram
module header_parameter_tokenizer_core import hpt_pkg::*; #(
    parameter int HELD_SPACE_DEPTH = 16
) (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     cfg_we,
    input  logic     cfg_wdata,
    input  logic     s_valid,
    output logic     s_ready,
    input  hpt_in_t  s_data,
    output logic     m_valid,
    input  logic     m_ready,
    output hpt_out_t m_data
);

    hpt_cmd_t  cmd;
    hpt_stat_t stat;

    hpt_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    hpt_datapath #(
        .HELD_SPACE_DEPTH(HELD_SPACE_DEPTH)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_data    (s_data),
        .cmd       (cmd),
        .stat      (stat),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

endmodule
